@@ design/c22_pkg.sv @@
// ----------------------------------------------------------------------------
// c22_pkg
// shared types, constants and fixed-point helpers for the c22 acceleration unit
// ----------------------------------------------------------------------------
package c22_pkg;

  localparam int NEWTON_STEPS = 8;
  localparam int NEWTON_DEPTH = 7;
  localparam int BACK_DEPTH   = 17;
  localparam int GEO_W        = 40;

  localparam logic [63:0] Y_INIT    = 64'h3000_0000_0000_0000;
  localparam logic [63:0] THREE_Q62 = 64'hC000_0000_0000_0000;
  localparam logic [63:0] POS_LIM   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] cos_angle;
    logic signed [31:0] sin_angle;
    logic signed [63:0] total_in_x;
    logic signed [63:0] total_in_y;
    logic signed [63:0] total_in_z;
  } c22_item_t;

  typedef struct packed {
    logic signed [63:0] acc_x;
    logic signed [63:0] acc_y;
    logic signed [63:0] acc_z;
    logic signed [63:0] total_out_x;
    logic signed [63:0] total_out_y;
    logic signed [63:0] total_out_z;
    logic               zero_radius;
  } c22_res_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [63:0] tot_x;
    logic signed [63:0] tot_y;
    logic signed [63:0] tot_z;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic [31:0]        mz;
    logic               nx;
    logic               ny;
    logic               nz;
    logic               zero;
    logic [4:0]         h;
    logic [63:0]        m62;
    logic [63:0]        y;
  } c22_ctx_t;

  typedef struct packed {
    c22_ctx_t           cx;
    logic signed [63:0] ux;
    logic signed [63:0] uy;
    logic signed [63:0] uz;
    logic [63:0]        yq;
    logic signed [63:0] d;
    logic signed [63:0] n;
    logic [63:0]        ky;
    logic signed [63:0] gx;
    logic signed [63:0] gy;
    logic signed [63:0] gz;
    logic signed [63:0] acc_x;
    logic signed [63:0] acc_y;
    logic signed [63:0] acc_z;
  } c22_bk_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // magnitude and sign to signed 64, saturating
  function automatic logic signed [63:0] sgn_of(input logic [63:0] m, input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = (m >= NEG_LIM) ? NEG_LIM : (~m + 64'd1);
    end else begin
      r = (m > POS_LIM) ? POS_LIM : m;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? NEG_LIM : POS_LIM;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // product scaled by 2^(16-4h), saturated to signed 64
  function automatic logic signed [63:0] scale_out(input logic [127:0] p, input logic neg,
                                                   input logic [4:0] h);
    logic [63:0]  lim;
    logic [63:0]  m;
    logic [4:0]   ls;
    logic [6:0]   rs;
    logic [127:0] q;
    lim = neg ? NEG_LIM : POS_LIM;
    ls  = 5'd16 - {h[2:0], 2'b00};
    rs  = {h, 2'b00} - 7'd16;
    q   = p >> rs;
    if (h <= 5'd4) begin
      m = (p[127:64] != 64'd0 || p[63:0] > (lim >> ls)) ? lim : (p[63:0] << ls);
    end else begin
      m = (q[127:64] != 64'd0 || q[63:0] > lim) ? lim : q[63:0];
    end
    return sgn_of(m, neg);
  endfunction

endpackage

@@ design/c22_if.sv @@
// ----------------------------------------------------------------------------
// c22_if
// valid/ready channels carrying one input word and one result word
// ----------------------------------------------------------------------------
interface c22_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] cos_angle;
  logic signed [31:0] sin_angle;
  logic signed [63:0] total_in_x;
  logic signed [63:0] total_in_y;
  logic signed [63:0] total_in_z;

  modport source (output valid, pos_x, pos_y, pos_z, cos_angle, sin_angle,
                  total_in_x, total_in_y, total_in_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, cos_angle, sin_angle,
                total_in_x, total_in_y, total_in_z, output ready);
endinterface

interface c22_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] acc_x;
  logic signed [63:0] acc_y;
  logic signed [63:0] acc_z;
  logic signed [63:0] total_out_x;
  logic signed [63:0] total_out_y;
  logic signed [63:0] total_out_z;
  logic               zero_radius;

  modport source (output valid, acc_x, acc_y, acc_z, total_out_x, total_out_y,
                  total_out_z, zero_radius, input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, total_out_x, total_out_y,
                total_out_z, zero_radius, output ready);
endinterface

@@ design/geopotential_c22_acceleration_unit.sv @@
// ----------------------------------------------------------------------------
// geopotential_c22_acceleration_unit
// c22 tesseral gravity acceleration with running total, fully pipelined
// ----------------------------------------------------------------------------
// datapath: front, newton steps and back end, then the output register
// throughput: one word per cycle; ready drops only while the output skid holds a word
// the 8 newton steps of the inverse square root make up most of the pipeline depth
// reset: pipeline and output valids clear, geo factor returns to zero
module geopotential_c22_acceleration_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [c22_pkg::GEO_W-1:0]  cfg_wdata,
  c22_in_if.sink                     in_ch,
  c22_out_if.source                  out_ch
);

  logic [c22_pkg::GEO_W-1:0] geo_r;
  logic                      en;
  c22_pkg::c22_item_t        item;
  c22_pkg::c22_ctx_t         nw_ctx [c22_pkg::NEWTON_STEPS+1];
  logic                      nw_v   [c22_pkg::NEWTON_STEPS+1];
  logic                      bk_v;
  c22_pkg::c22_res_t         bk_res;
  c22_pkg::c22_res_t         out_r, skid_r;
  logic                      out_v_r, skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_r <= '0;
    end else if (cfg_we) begin
      geo_r <= cfg_wdata;
    end
  end

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  assign item.pos_x      = in_ch.pos_x;
  assign item.pos_y      = in_ch.pos_y;
  assign item.pos_z      = in_ch.pos_z;
  assign item.cos_angle  = in_ch.cos_angle;
  assign item.sin_angle  = in_ch.sin_angle;
  assign item.total_in_x = in_ch.total_in_x;
  assign item.total_in_y = in_ch.total_in_y;
  assign item.total_in_z = in_ch.total_in_z;

  c22_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_ch.valid), .item(item),
    .out_v(nw_v[0]), .ctx_o(nw_ctx[0])
  );

  for (genvar i = 0; i < c22_pkg::NEWTON_STEPS; i++) begin : g_newton
    c22_newton u_newton (
      .clk(clk), .rst_n(rst_n), .en(en), .in_v(nw_v[i]), .ctx_i(nw_ctx[i]),
      .out_v(nw_v[i+1]), .ctx_o(nw_ctx[i+1])
    );
  end

  c22_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(nw_v[c22_pkg::NEWTON_STEPS]),
    .ctx_i(nw_ctx[c22_pkg::NEWTON_STEPS]), .geo(geo_r), .out_v(bk_v), .res(bk_res)
  );

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ch.ready || !out_v_r) begin
      out_v_r  <= skid_v_r | bk_v;
      skid_v_r <= 1'b0;
    end else if (!skid_v_r) begin
      skid_v_r <= bk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : bk_res;
    end else if (!skid_v_r) begin
      skid_r <= bk_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.acc_x       = out_r.acc_x;
  assign out_ch.acc_y       = out_r.acc_y;
  assign out_ch.acc_z       = out_r.acc_z;
  assign out_ch.total_out_x = out_r.total_out_x;
  assign out_ch.total_out_y = out_r.total_out_y;
  assign out_ch.total_out_z = out_r.total_out_z;
  assign out_ch.zero_radius = out_r.zero_radius;

endmodule

@@ design/c22_mul64.sv @@
// ----------------------------------------------------------------------------
// c22_mul64
// two-stage 64x64 unsigned multiplier from four 32x32 partial products
// ----------------------------------------------------------------------------
module c22_mul64 (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      pp01_r <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
      pp10_r <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
      pp11_r <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= {pp11_r, pp00_r} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0};
    end
  end

endmodule

@@ design/c22_front.sv @@
// ----------------------------------------------------------------------------
// c22_front
// earth-fixed rotation, r^2, and normalization of r^2 to [1,4)
// ----------------------------------------------------------------------------
module c22_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  c22_pkg::c22_item_t  item,
  output logic                out_v,
  output c22_pkg::c22_ctx_t   ctx_o
);

  logic [5:0] v_r;

  // stage 1
  logic [63:0]        p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic               n_xc_r, n_ys_r, n_yc_r, n_xs_r;
  logic signed [31:0] pz1_r, c1_r, s1_r;
  logic signed [63:0] tx1_r, ty1_r, tz1_r;
  // stage 2
  c22_pkg::c22_ctx_t  cx2_r, cx3_r, cx4_r, cx5_r, cx6_r;
  // stage 3
  logic [63:0]        sqx_r, sqy_r, sqz_r;
  // stage 4, 5
  logic [63:0]        r2_r, r2b_r;
  logic [4:0]         h5_r;

  logic [31:0]        am_x, am_y, am_c, am_s;
  logic signed [35:0] t_xc, t_ys, t_yc, t_xs, sum_x, sum_y;
  logic [31:0]        xe, ye;
  logic [5:0]         lead;
  logic [5:0]         shamt;
  logic [63:0]        r2_sum;
  c22_pkg::c22_ctx_t  cx2_nxt;
  c22_pkg::c22_ctx_t  cx4_nxt;
  c22_pkg::c22_ctx_t  cx6_nxt;

  function automatic logic [31:0] clamp32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    am_x = c22_pkg::mag32(item.pos_x);
    am_y = c22_pkg::mag32(item.pos_y);
    am_c = c22_pkg::mag32(item.cos_angle);
    am_s = c22_pkg::mag32(item.sin_angle);

    t_xc  = n_xc_r ? -$signed({2'b00, p_xc_r[63:30]}) : $signed({2'b00, p_xc_r[63:30]});
    t_ys  = n_ys_r ? -$signed({2'b00, p_ys_r[63:30]}) : $signed({2'b00, p_ys_r[63:30]});
    t_yc  = n_yc_r ? -$signed({2'b00, p_yc_r[63:30]}) : $signed({2'b00, p_yc_r[63:30]});
    t_xs  = n_xs_r ? -$signed({2'b00, p_xs_r[63:30]}) : $signed({2'b00, p_xs_r[63:30]});
    sum_x = t_xc + t_ys;
    sum_y = t_yc - t_xs;
    xe    = clamp32(sum_x);
    ye    = clamp32(sum_y);

    cx2_nxt       = '0;
    cx2_nxt.c     = c1_r;
    cx2_nxt.s     = s1_r;
    cx2_nxt.tot_x = tx1_r;
    cx2_nxt.tot_y = ty1_r;
    cx2_nxt.tot_z = tz1_r;
    cx2_nxt.mx    = c22_pkg::mag32(xe);
    cx2_nxt.my    = c22_pkg::mag32(ye);
    cx2_nxt.mz    = c22_pkg::mag32(pz1_r);
    cx2_nxt.nx    = xe[31];
    cx2_nxt.ny    = ye[31];
    cx2_nxt.nz    = pz1_r[31];
    cx2_nxt.y     = c22_pkg::Y_INIT;

    r2_sum       = sqx_r + sqy_r + sqz_r;
    cx4_nxt      = cx3_r;
    cx4_nxt.zero = (r2_sum == 64'd0);

    lead = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (r2_r[i]) begin
        lead = 6'(i);
      end
    end
    shamt = 6'd62 - {h5_r, 1'b0};

    cx6_nxt     = cx5_r;
    cx6_nxt.h   = h5_r;
    cx6_nxt.m62 = r2b_r << shamt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc_r <= {32'd0, am_x} * {32'd0, am_c};
      p_ys_r <= {32'd0, am_y} * {32'd0, am_s};
      p_yc_r <= {32'd0, am_y} * {32'd0, am_c};
      p_xs_r <= {32'd0, am_x} * {32'd0, am_s};
      n_xc_r <= item.pos_x[31] ^ item.cos_angle[31];
      n_ys_r <= item.pos_y[31] ^ item.sin_angle[31];
      n_yc_r <= item.pos_y[31] ^ item.cos_angle[31];
      n_xs_r <= item.pos_x[31] ^ item.sin_angle[31];
      pz1_r  <= item.pos_z;
      c1_r   <= item.cos_angle;
      s1_r   <= item.sin_angle;
      tx1_r  <= item.total_in_x;
      ty1_r  <= item.total_in_y;
      tz1_r  <= item.total_in_z;

      cx2_r <= cx2_nxt;

      sqx_r <= {32'd0, cx2_r.mx} * {32'd0, cx2_r.mx};
      sqy_r <= {32'd0, cx2_r.my} * {32'd0, cx2_r.my};
      sqz_r <= {32'd0, cx2_r.mz} * {32'd0, cx2_r.mz};
      cx3_r <= cx2_r;

      r2_r  <= r2_sum;
      cx4_r <= cx4_nxt;

      r2b_r <= r2_r;
      h5_r  <= lead[5:1];
      cx5_r <= cx4_r;

      cx6_r <= cx6_nxt;
    end
  end

  assign out_v = v_r[5];
  assign ctx_o = cx6_r;

endmodule

@@ design/c22_newton.sv @@
// ----------------------------------------------------------------------------
// c22_newton
// one newton step of the inverse square root: y = y*(3 - m*y^2)/2
// ----------------------------------------------------------------------------
module c22_newton (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  c22_pkg::c22_ctx_t  ctx_i,
  output logic               out_v,
  output c22_pkg::c22_ctx_t  ctx_o
);

  c22_pkg::c22_ctx_t ctx_r [c22_pkg::NEWTON_DEPTH];
  logic [c22_pkg::NEWTON_DEPTH-1:0] v_r;
  logic [63:0]  t_r;
  logic [127:0] p1, p2, p3;
  logic [63:0]  pm;

  c22_mul64 u_sq (.clk(clk), .en(en), .a(ctx_i.y), .b(ctx_i.y), .p(p1));
  c22_mul64 u_my (.clk(clk), .en(en), .a(ctx_r[1].m62), .b(p1[125:62]), .p(p2));
  c22_mul64 u_yt (.clk(clk), .en(en), .a(ctx_r[4].y), .b(t_r), .p(p3));

  assign pm = p2[125:62];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[c22_pkg::NEWTON_DEPTH-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_i;
      for (int k = 1; k < c22_pkg::NEWTON_DEPTH; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
      t_r <= (pm < c22_pkg::THREE_Q62) ? (c22_pkg::THREE_Q62 - pm) : 64'd0;
    end
  end

  always_comb begin
    ctx_o   = ctx_r[c22_pkg::NEWTON_DEPTH-1];
    ctx_o.y = p3[126:63];
  end

  assign out_v = v_r[c22_pkg::NEWTON_DEPTH-1];

endmodule

@@ design/c22_back.sv @@
// ----------------------------------------------------------------------------
// c22_back
// unit vector, c22 polynomial, back rotation, output scaling and totals
// ----------------------------------------------------------------------------
module c22_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  c22_pkg::c22_ctx_t             ctx_i,
  input  logic [c22_pkg::GEO_W-1:0]     geo,
  output logic                          out_v,
  output c22_pkg::c22_res_t             res
);

  localparam int L = c22_pkg::BACK_DEPTH;

  c22_pkg::c22_bk_t st_r   [L];
  c22_pkg::c22_bk_t st_nxt [L];
  logic [L-1:0]     v_r;

  logic [63:0]  a0 [4], b0 [4], a3 [3], b3 [3], a7 [4], b7 [4];
  logic [63:0]  a10 [4], b10 [4], a13 [3], b13 [3];
  logic [127:0] p0 [4], p3 [3], p7 [4], p10 [4], p13 [3];
  logic [5:0]   ush;
  logic [66:0]  d5;
  logic [63:0]  dm;
  logic signed [63:0] sxx, syy, s_gx, s_gy, s_gz, s_xc, s_ys, s_xs, s_yc;

  for (genvar i = 0; i < 4; i++) begin : g_m4
    c22_mul64 u_m0  (.clk(clk), .en(en), .a(a0[i]),  .b(b0[i]),  .p(p0[i]));
    c22_mul64 u_m7  (.clk(clk), .en(en), .a(a7[i]),  .b(b7[i]),  .p(p7[i]));
    c22_mul64 u_m10 (.clk(clk), .en(en), .a(a10[i]), .b(b10[i]), .p(p10[i]));
  end
  for (genvar i = 0; i < 3; i++) begin : g_m3
    c22_mul64 u_m3  (.clk(clk), .en(en), .a(a3[i]),  .b(b3[i]),  .p(p3[i]));
    c22_mul64 u_m13 (.clk(clk), .en(en), .a(a13[i]), .b(b13[i]), .p(p13[i]));
  end

  always_comb begin
    // unit vector and y^2
    a0[0] = {32'd0, ctx_i.mx};  b0[0] = ctx_i.y;
    a0[1] = {32'd0, ctx_i.my};  b0[1] = ctx_i.y;
    a0[2] = {32'd0, ctx_i.mz};  b0[2] = ctx_i.y;
    a0[3] = ctx_i.y;            b0[3] = ctx_i.y;
    // squares and y^4
    a3[0] = c22_pkg::mag64(st_r[2].ux); b3[0] = c22_pkg::mag64(st_r[2].ux);
    a3[1] = c22_pkg::mag64(st_r[2].uy); b3[1] = c22_pkg::mag64(st_r[2].uy);
    a3[2] = st_r[2].yq;                 b3[2] = st_r[2].yq;
    // n times unit vector, k times y^4
    a7[0] = c22_pkg::mag64(st_r[6].n);  b7[0] = c22_pkg::mag64(st_r[6].ux);
    a7[1] = c22_pkg::mag64(st_r[6].n);  b7[1] = c22_pkg::mag64(st_r[6].uy);
    a7[2] = c22_pkg::mag64(st_r[6].n);  b7[2] = c22_pkg::mag64(st_r[6].uz);
    a7[3] = {24'd0, geo};               b7[3] = st_r[6].yq;
    // back rotation
    a10[0] = c22_pkg::mag64(st_r[9].gx); b10[0] = {32'd0, c22_pkg::mag32(st_r[9].cx.c)};
    a10[1] = c22_pkg::mag64(st_r[9].gy); b10[1] = {32'd0, c22_pkg::mag32(st_r[9].cx.s)};
    a10[2] = c22_pkg::mag64(st_r[9].gx); b10[2] = {32'd0, c22_pkg::mag32(st_r[9].cx.s)};
    a10[3] = c22_pkg::mag64(st_r[9].gy); b10[3] = {32'd0, c22_pkg::mag32(st_r[9].cx.c)};
    // output scaling
    a13[0] = st_r[12].ky; b13[0] = c22_pkg::mag64(st_r[12].gx);
    a13[1] = st_r[12].ky; b13[1] = c22_pkg::mag64(st_r[12].gy);
    a13[2] = st_r[12].ky; b13[2] = c22_pkg::mag64(st_r[12].gz);

    ush = {1'b0, st_r[1].cx.h} + 6'd4;
    dm  = c22_pkg::mag64(st_r[5].d);
    d5  = {3'b000, dm} + {1'b0, dm, 2'b00};
    sxx = c22_pkg::sgn_of(p3[0][121:58], 1'b0);
    syy = c22_pkg::sgn_of(p3[1][121:58], 1'b0);
    s_gx = c22_pkg::sgn_of(p7[0][121:58], st_r[8].n[63] ^ st_r[8].ux[63]);
    s_gy = c22_pkg::sgn_of(p7[1][121:58], st_r[8].n[63] ^ st_r[8].uy[63]);
    s_gz = c22_pkg::sgn_of(p7[2][121:58], st_r[8].n[63] ^ st_r[8].uz[63]);
    s_xc = c22_pkg::sgn_of(p10[0][93:30], st_r[11].gx[63] ^ st_r[11].cx.c[31]);
    s_ys = c22_pkg::sgn_of(p10[1][93:30], st_r[11].gy[63] ^ st_r[11].cx.s[31]);
    s_xs = c22_pkg::sgn_of(p10[2][93:30], st_r[11].gx[63] ^ st_r[11].cx.s[31]);
    s_yc = c22_pkg::sgn_of(p10[3][93:30], st_r[11].gy[63] ^ st_r[11].cx.c[31]);

    st_nxt[0]    = '0;
    st_nxt[0].cx = ctx_i;
    for (int k = 1; k < L; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    st_nxt[2].ux = c22_pkg::sgn_of(64'(p0[0] >> ush), st_r[1].cx.nx);
    st_nxt[2].uy = c22_pkg::sgn_of(64'(p0[1] >> ush), st_r[1].cx.ny);
    st_nxt[2].uz = c22_pkg::sgn_of(64'(p0[2] >> ush), st_r[1].cx.nz);
    st_nxt[2].yq = p0[3][125:62];

    st_nxt[5].d  = syy - sxx;
    st_nxt[5].yq = p3[2][125:62];

    st_nxt[6].n = c22_pkg::sgn_of(d5[64:1], st_r[5].d[63]);

    st_nxt[9].gx = st_r[8].ux + s_gx;
    st_nxt[9].gy = s_gy - st_r[8].uy;
    st_nxt[9].gz = s_gz;
    st_nxt[9].ky = p7[3][103:40];

    st_nxt[12].gx = s_xc - s_ys;
    st_nxt[12].gy = s_xs + s_yc;

    if (st_r[14].cx.zero) begin
      st_nxt[15].acc_x = '0;
      st_nxt[15].acc_y = '0;
      st_nxt[15].acc_z = '0;
    end else begin
      st_nxt[15].acc_x = c22_pkg::scale_out(p13[0], st_r[14].gx[63], st_r[14].cx.h);
      st_nxt[15].acc_y = c22_pkg::scale_out(p13[1], st_r[14].gy[63], st_r[14].cx.h);
      st_nxt[15].acc_z = c22_pkg::scale_out(p13[2], st_r[14].gz[63], st_r[14].cx.h);
    end

    st_nxt[16].cx.tot_x = c22_pkg::sat_add(st_r[15].cx.tot_x, st_r[15].acc_x);
    st_nxt[16].cx.tot_y = c22_pkg::sat_add(st_r[15].cx.tot_y, st_r[15].acc_y);
    st_nxt[16].cx.tot_z = c22_pkg::sat_add(st_r[15].cx.tot_z, st_r[15].acc_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[L-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_v             = v_r[L-1];
  assign res.acc_x         = st_r[L-1].acc_x;
  assign res.acc_y         = st_r[L-1].acc_y;
  assign res.acc_z         = st_r[L-1].acc_z;
  assign res.total_out_x   = st_r[L-1].cx.tot_x;
  assign res.total_out_y   = st_r[L-1].cx.tot_y;
  assign res.total_out_z   = st_r[L-1].cx.tot_z;
  assign res.zero_radius   = st_r[L-1].cx.zero;

endmodule
